// ----- rtl/sli_pkg.sv -----
package sli_pkg;

    // store geometry
    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int VAL_W         = 32;
    localparam int OPC_W         = 3;
    localparam int STAT_W        = 2;
    localparam int ENTRY_COUNT_W = 6;

    // stream widths, padded to whole bytes
    localparam int IN_BITS     = OPC_W + VAL_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = VAL_W + ENTRY_COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // opcodes
    localparam logic [OPC_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OPC_W-1:0] OP_DELETE    = 3'd1;
    localparam logic [OPC_W-1:0] OP_COUNT     = 3'd2;
    localparam logic [OPC_W-1:0] OP_DUMP_UP   = 3'd3;
    localparam logic [OPC_W-1:0] OP_DUMP_DOWN = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic latch;  // take the input beat into the operation registers
        logic emit;   // run the operation step and load one result beat
    } sli_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // result register can take a beat this cycle
        logic multi;      // dump of a non-empty store, one beat per entry
        logic last_beat;  // the dump pointer sits on the final entry
    } sli_sts_t;

endpackage

// ----- rtl/sorted_list_insert_delete_top.sv -----
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+------------------------------------------------
// command  | in  | s_tvalid/s_tready | s_tdata: opcode, operand_value
// result   | out | m_tvalid/m_tready | m_tdata: element, entry_count; m_tuser: status;
//          |     |                   | m_tlast: last
//
// one command at a time: a beat is taken into the operation registers and its first
// result is loaded into the output register once that register is free; a dump of
// n > 0 entries gives n result beats, one read of the cell array per result beat.
// a waiting result does not block the next command beat.
// m_tready low holds the result register and the dump pointer. rst_n clears the
// fill level and the control state; the cell array itself has no reset.
module sorted_list_insert_delete_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sli_pkg::IN_TDATA_W-1:0]      s_tdata,   // opcode, operand_value, zero pad
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sli_pkg::OUT_TDATA_W-1:0]     m_tdata,   // element, entry_count, zero pad
    output logic [sli_pkg::STAT_W-1:0]          m_tuser,   // status
    output logic                                m_tlast
);
    import sli_pkg::*;

    sli_cmd_t cmd;
    sli_sts_t sts;

    logic [OPC_W-1:0]         in_opcode;
    logic signed [VAL_W-1:0]  in_value;
    logic signed [VAL_W-1:0]  out_element;
    logic [ENTRY_COUNT_W-1:0] out_count;

    // unpack the command beat, opcode in the low bits
    assign in_opcode = s_tdata[OPC_W-1:0];
    assign in_value  = s_tdata[OPC_W +: VAL_W];

    // sequencer: accept, step, and walk the dump one beat at a time
    sli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // compare-and-shift cell array with the result register
    sli_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_opcode   (in_opcode),
        .in_value    (in_value),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_element (out_element),
        .out_count   (out_count),
        .out_last    (m_tlast)
    );

    // pack the result beat, element in the low bits
    assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_count, out_element};

endmodule

// ----- rtl/sli_ctrl.sv -----
module sli_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sli_pkg::sli_sts_t sts,
    output sli_pkg::sli_cmd_t cmd
);
    import sli_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.latch  = 1'b0;
        cmd.emit   = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    // a dump with more entries carries on beat by beat
                    if (sts.multi && !sts.last_beat)
                    begin
                        state_next = S_DUMP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_beat)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sli_dp.sv -----
module sli_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sli_pkg::sli_cmd_t                  cmd,
    output sli_pkg::sli_sts_t                  sts,
    input  logic [sli_pkg::OPC_W-1:0]          in_opcode,
    input  logic signed [sli_pkg::VAL_W-1:0]   in_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sli_pkg::STAT_W-1:0]         out_status,
    output logic signed [sli_pkg::VAL_W-1:0]   out_element,
    output logic [sli_pkg::ENTRY_COUNT_W-1:0]  out_count,
    output logic                               out_last
);
    import sli_pkg::*;

    // cell array, no reset: places at or above the fill level never reach a result
    logic signed [VAL_W-1:0] entry_reg  [DEPTH];
    logic signed [VAL_W-1:0] entry_next [DEPTH];

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;

    logic [OPC_W-1:0]        op_reg;
    logic signed [VAL_W-1:0] val_reg;

    logic                     out_valid_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic signed [VAL_W-1:0]  out_element_reg;
    logic [ENTRY_COUNT_W-1:0] out_count_reg;
    logic                     out_last_reg;

    logic [DEPTH-1:0] ins_mark;  // places at or past the insert point
    logic [DEPTH-1:0] eq_hit;
    logic [DEPTH-1:0] del_mark;  // places at or past the first match
    logic [DEPTH-1:0] scan [IDX_W+1];

    logic                    empty;
    logic                    full;
    logic                    found;
    logic                    is_dump;
    logic [CNT_W-1:0]        fill_dec;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [VAL_W-1:0] rd_data;

    logic [STAT_W-1:0]       res_status;
    logic signed [VAL_W-1:0] res_element;
    logic                    res_last;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg >= CNT_W'(DEPTH));
    assign fill_dec = fill_reg - CNT_W'(1);
    assign is_dump  = (op_reg == OP_DUMP_UP) || (op_reg == OP_DUMP_DOWN);

    // per-cell compares against the operand
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ins_mark[i] = (CNT_W'(i) >= fill_reg) || (entry_reg[i] > val_reg);
            eq_hit[i]   = (CNT_W'(i) < fill_reg) && (entry_reg[i] == val_reg);
        end
    end

    // log-depth prefix or of the equality hits
    always_comb
    begin
        scan[0] = eq_hit;
        for (int s = 0; s < IDX_W; s++)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i >= (1 << s))
                begin
                    scan[s+1][i] = scan[s][i] | scan[s][i - (1 << s)];
                end
                else
                begin
                    scan[s+1][i] = scan[s][i];
                end
            end
        end
    end

    assign del_mark = scan[IDX_W];
    assign found    = del_mark[DEPTH-1];

    // dump read port
    assign rd_addr = (op_reg == OP_DUMP_UP) ? ptr_reg
                                            : (fill_dec[IDX_W-1:0] - ptr_reg);
    assign rd_data = entry_reg[rd_addr];

    assign sts.multi     = is_dump && !empty;
    assign sts.last_beat = (CNT_W'(ptr_reg) == fill_dec);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // operation step
    always_comb
    begin
        entry_next  = entry_reg;
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        res_status  = ST_OK;
        res_element = '0;
        res_last    = 1'b1;
        if (cmd.latch)
        begin
            ptr_next = '0;
        end
        if (cmd.emit)
        begin
            unique case (op_reg)
                OP_INSERT:
                begin
                    if (full)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (ins_mark[i])
                            begin
                                if (i > 0 && ins_mark[(i > 0) ? i - 1 : 0])
                                begin
                                    entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                                end
                                else
                                begin
                                    entry_next[i] = val_reg;
                                end
                            end
                        end
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        res_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            if (del_mark[i])
                            begin
                                entry_next[i] = entry_reg[i+1];
                            end
                        end
                        fill_next = fill_dec;
                    end
                end
                OP_DUMP_UP, OP_DUMP_DOWN:
                begin
                    if (empty)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        res_element = rd_data;
                        res_last    = sts.last_beat;
                        ptr_next    = ptr_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
        if (cmd.latch)
        begin
            op_reg  <= in_opcode;
            val_reg <= in_value;
        end
        if (cmd.emit)
        begin
            out_status_reg  <= res_status;
            out_element_reg <= res_element;
            out_count_reg   <= ENTRY_COUNT_W'(fill_next);
            out_last_reg    <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_element = out_element_reg;
    assign out_count   = out_count_reg;
    assign out_last    = out_last_reg;

endmodule
